// ----- design/wfrps_pkg.sv -----
package wfrps_pkg;

	localparam int KEY_W = 32;
	localparam int SIZE_W = 16;
	localparam int STATUS_W = 3;
	localparam int REC_COST = 4;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FAILED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DIR_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DISPLAY = 3'd6;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_DISPLAY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DISP,
		S_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic scan_clear;
		logic scan_step;
		logic alloc_page;
		logic shift_rd;
		logic shift_wr;
		logic place;
		logic srch_start;
		logic srch_rd;
		logic srch_next;
		logic disp_start;
		logic disp_next;
		logic emit;
		logic [STATUS_W-1:0] status;
		logic emit_slot;
		logic emit_none;
		logic last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic scan_done;
		logic have_pages;
		logic best_fits;
		logic best_dir_full;
		logic table_full;
		logic new_fits;
		logic shift_stop;
		logic srch_hit;
		logic srch_page_done;
		logic srch_all_done;
		logic disp_empty;
		logic disp_last;
		logic out_busy;
	} stat_t;

endpackage

// ----- design/wfrps_if.sv -----
interface wfrps_in_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [15:0] record_size;
	logic signed [31:0] key;
	modport source(output valid, mode, record_size, key, input ready);
	modport sink(input valid, mode, record_size, key, output ready);
endinterface

interface wfrps_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic signed [4:0] page_number;
	logic signed [6:0] slot_number;
	logic [6:0] records_in_page;
	logic [4:0] pages_in_use;
	logic last_result;
	modport source(output valid, status, page_number, slot_number, records_in_page,
		pages_in_use, last_result, input ready);
	modport sink(input valid, status, page_number, slot_number, records_in_page,
		pages_in_use, last_result, output ready);
endinterface

// ----- design/wfrps_ctrl.sv -----
module wfrps_ctrl
	import wfrps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic [STATUS_W-1:0] pend_st_q, pend_st_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_st_q <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			pend_st_q <= pend_st_d;
		end
	end

	// Sequence one item
	always_comb begin
		state_d = state_q;
		pend_st_d = pend_st_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (st.mode == MODE_INSERT) begin
					cmd.scan_step = 1'b1;
					if (st.scan_done) state_d = S_DECIDE;
				end else if (st.mode == MODE_SEARCH) begin
					cmd.srch_start = 1'b1;
					state_d = S_SRCH_RD;
				end else if (st.mode == MODE_DISPLAY) begin
					cmd.disp_start = 1'b1;
					state_d = S_DISP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DECIDE: begin
				priority if (st.have_pages && st.best_fits && st.best_dir_full) begin
					pend_st_d = ST_DIR_FULL;
					state_d = S_OUT;
				end else if (st.have_pages && st.best_fits) begin
					state_d = S_SHIFT_RD;
				end else if (st.table_full) begin
					pend_st_d = ST_TABLE_FULL;
					state_d = S_OUT;
				end else begin
					cmd.alloc_page = 1'b1;
					if (st.new_fits) state_d = S_SHIFT_RD;
					else begin
						pend_st_d = ST_FAILED;
						state_d = S_OUT;
					end
				end
			end
			S_SHIFT_RD: begin
				cmd.shift_rd = 1'b1;
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				if (st.shift_stop) state_d = S_PLACE;
				else begin
					cmd.shift_wr = 1'b1;
					state_d = S_SHIFT_RD;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				pend_st_d = ST_INSERTED;
				state_d = S_OUT;
			end
			S_SRCH_RD: begin
				priority if (st.srch_all_done) begin
					pend_st_d = ST_NOT_FOUND;
					state_d = S_OUT;
				end else if (st.srch_page_done) begin
					cmd.srch_next = 1'b1;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (st.srch_hit) begin
					pend_st_d = ST_FOUND;
					state_d = S_OUT;
				end else begin
					cmd.srch_next = 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_DISP: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					cmd.status = ST_DISPLAY;
					cmd.emit_none = st.disp_empty;
					cmd.last = st.disp_empty || st.disp_last;
					cmd.disp_next = 1'b1;
					if (cmd.last) state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					cmd.status = pend_st_q;
					cmd.last = 1'b1;
					cmd.emit_slot = (pend_st_q == ST_INSERTED) || (pend_st_q == ST_FOUND);
					cmd.emit_none = (pend_st_q == ST_TABLE_FULL) || (pend_st_q == ST_NOT_FOUND);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- design/wfrps_dpath.sv -----
module wfrps_dpath
	import wfrps_pkg::*;
#(
	parameter int MAX_PAGES = 16,
	parameter int MAX_RECORDS = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	input  logic [1:0] in_mode,
	input  logic [SIZE_W-1:0] in_size,
	input  logic [KEY_W-1:0] in_key,
	input  cmd_t cmd,
	output stat_t st,
	wfrps_out_if.source out
);

	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int RCW = $clog2(MAX_RECORDS + 1);
	localparam int DEPTH = MAX_PAGES * MAX_RECORDS;
	localparam int AW = PW + RW;

	logic [15:0] pg_bytes_q;
	logic [1:0] mode_q;
	logic [SIZE_W-1:0] size_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PCW-1:0] alloc_q;
	logic [15:0] free_q [MAX_PAGES];
	logic [RCW-1:0] cnt_q [MAX_PAGES];
	logic [KEY_W-1:0] dkey_mem [DEPTH];
	logic [SIZE_W-1:0] dsize_mem [DEPTH];
	logic [KEY_W-1:0] rd_key_q;
	logic [SIZE_W-1:0] rd_size_q;

	logic [PCW-1:0] scan_q;
	logic [PW-1:0] best_q, tgt_q;
	logic [15:0] best_free_q;
	logic [RCW-1:0] pos_q;
	logic [RCW-1:0] ridx_q;
	logic [PCW-1:0] spage_q;

	logic [16:0] cost;
	logic [15:0] new_free;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic mem_we;
	logic [RW-1:0] pos_m1;
	logic [RCW-1:0] cur_cnt;
	logic [PW-1:0] spage_i;

	// Output register
	logic ov_q;
	logic [2:0] o_status_q;
	logic signed [4:0] o_page_q;
	logic signed [6:0] o_slot_q;
	logic [6:0] o_cnt_q;
	logic [4:0] o_pages_q;
	logic last_q;

	assign cost = {1'b0, size_q} + 17'(REC_COST);
	assign new_free = (pg_bytes_q > 16'(HEADER_BYTES)) ?
		pg_bytes_q - 16'(HEADER_BYTES) : 16'd0;
	assign pos_m1 = RW'(pos_q - RCW'(1));
	assign spage_i = spage_q[PW-1:0];
	assign cur_cnt = cnt_q[spage_i];

	// Configuration and item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_bytes_q <= 16'd4096;
			alloc_q <= '0;
			mode_q <= '0;
		end else begin
			if (cfg_we) pg_bytes_q <= cfg_data;
			if (cmd.load_item) mode_q <= in_mode;
			if (cmd.alloc_page) alloc_q <= alloc_q + PCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			size_q <= in_size;
			key_q <= in_key;
		end
	end

	// Worst-fit scan, one page per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			scan_q <= '0;
			best_q <= '0;
			best_free_q <= '0;
		end else if (cmd.scan_step && !st.scan_done) begin
			if (scan_q == '0 || free_q[scan_q[PW-1:0]] > best_free_q) begin
				best_q <= scan_q[PW-1:0];
				best_free_q <= free_q[scan_q[PW-1:0]];
			end
			scan_q <= scan_q + PCW'(1);
		end
	end

	// Target page and insertion position
	always_ff @(posedge clk) begin
		if (cmd.scan_step && st.scan_done) begin
			tgt_q <= best_q;
			pos_q <= cnt_q[best_q];
		end else if (cmd.alloc_page) begin
			tgt_q <= alloc_q[PW-1:0];
			pos_q <= '0;
		end else if (cmd.shift_wr) begin
			pos_q <= pos_q - RCW'(1);
		end
	end

	// Page table
	always_ff @(posedge clk) begin
		if (cmd.alloc_page) begin
			free_q[alloc_q[PW-1:0]] <= new_free;
			cnt_q[alloc_q[PW-1:0]] <= '0;
		end else if (cmd.place) begin
			free_q[tgt_q] <= free_q[tgt_q] - cost[15:0];
			cnt_q[tgt_q] <= cnt_q[tgt_q] + RCW'(1);
		end
	end

	// Directory memory: one read and one write port
	always_comb begin
		if (cmd.srch_rd) rd_addr = {spage_i, ridx_q[RW-1:0]};
		else rd_addr = {tgt_q, pos_m1};
		mem_we = cmd.shift_wr || cmd.place;
		if (cmd.place) wr_addr = {tgt_q, pos_q[RW-1:0]};
		else wr_addr = {tgt_q, RW'(pos_q)};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dkey_mem[wr_addr] <= cmd.place ? key_q : rd_key_q;
			dsize_mem[wr_addr] <= cmd.place ? size_q : rd_size_q;
		end
		if (cmd.shift_rd || cmd.srch_rd) begin
			rd_key_q <= dkey_mem[rd_addr];
			rd_size_q <= dsize_mem[rd_addr];
		end
	end

	// Search and display walk
	always_ff @(posedge clk) begin
		if (cmd.srch_start || cmd.disp_start) begin
			spage_q <= '0;
			ridx_q <= '0;
		end else if (cmd.disp_next) begin
			spage_q <= spage_q + PCW'(1);
		end else if (cmd.srch_next) begin
			if (st.srch_page_done) begin
				spage_q <= spage_q + PCW'(1);
				ridx_q <= '0;
			end else begin
				ridx_q <= ridx_q + RCW'(1);
			end
		end
	end

	// Status to controller
	always_comb begin
		st = '0;
		st.mode = mode_q;
		st.scan_done = (scan_q == alloc_q);
		st.have_pages = (alloc_q != '0);
		st.best_fits = {1'b0, best_free_q} >= cost;
		st.best_dir_full = (cnt_q[best_q] >= RCW'(MAX_RECORDS));
		st.table_full = (alloc_q >= PCW'(MAX_PAGES));
		st.new_fits = {1'b0, new_free} >= cost;
		st.shift_stop = (pos_q == '0) || ($signed(rd_key_q) < key_q) ||
			(($signed(rd_key_q) == key_q) && (rd_size_q <= size_q));
		st.srch_all_done = (spage_q >= alloc_q);
		st.srch_page_done = (ridx_q >= cur_cnt);
		st.srch_hit = ($signed(rd_key_q) == key_q);
		st.disp_empty = (alloc_q == '0);
		st.disp_last = (spage_q + PCW'(1) == alloc_q);
		st.out_busy = ov_q && !out.ready;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.emit) ov_q <= 1'b1;
		else if (out.ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_status_q <= cmd.status;
			last_q <= cmd.last;
			o_pages_q <= 5'(alloc_q);
			if (cmd.emit_none) begin
				o_page_q <= -5'sd1;
				o_cnt_q <= '0;
			end else if (cmd.status == ST_DISPLAY || cmd.status == ST_FOUND) begin
				o_page_q <= 5'(spage_q);
				o_cnt_q <= 7'(cur_cnt);
			end else if (cmd.status == ST_FAILED) begin
				o_page_q <= 5'(tgt_q);
				o_cnt_q <= '0;
			end else begin
				o_page_q <= 5'(tgt_q);
				o_cnt_q <= 7'(cnt_q[tgt_q]);
			end
			if (!cmd.emit_slot) o_slot_q <= -7'sd1;
			else if (cmd.status == ST_FOUND) o_slot_q <= 7'(ridx_q);
			else o_slot_q <= 7'(pos_q);
		end
	end

	assign out.valid = ov_q;
	assign out.status = o_status_q;
	assign out.page_number = o_page_q;
	assign out.slot_number = o_slot_q;
	assign out.records_in_page = o_cnt_q;
	assign out.pages_in_use = o_pages_q;
	assign out.last_result = last_q;

endmodule

// ----- design/worst_fit_record_page_store.sv -----
// From the input transfer to a valid result: an insert scans every page, then shifts
// records one read and write at a time and places the new one; a search reads stored records in
// turn; display emits one line per page; receiver stalls add delay.
// Throughput: one item at a time, set by the page scan and the directory memory walk
// (one read and one write port); the next item is taken once its last result is registered.
// Reset: arst_n clears control, page count and the page size register (4096); directory
// contents stay undefined until written.
module worst_fit_record_page_store
	import wfrps_pkg::*;
#(
	parameter int MAX_PAGES = 16,
	parameter int MAX_RECORDS = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	wfrps_in_if.sink in_ch,
	wfrps_out_if.source out_ch
);

	cmd_t cmd;
	stat_t st;
	logic rdy;

	assign in_ch.ready = rdy;

	wfrps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(rdy),
		.st(st),
		.cmd(cmd)
	);

	wfrps_dpath #(
		.MAX_PAGES(MAX_PAGES),
		.MAX_RECORDS(MAX_RECORDS),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_mode(in_ch.mode),
		.in_size(in_ch.record_size),
		.in_key(in_ch.key),
		.cmd(cmd),
		.st(st),
		.out(out_ch)
	);

endmodule

// ----- tb/sv/wfrps_chk.sv -----
module wfrps_chk
	import wfrps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [1:0] in_mode,
	input  logic [15:0] in_size,
	input  logic signed [31:0] in_key,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [2:0] out_status,
	input  logic signed [4:0] out_page,
	input  logic signed [6:0] out_slot,
	input  logic [6:0] out_count,
	input  logic [4:0] out_pages,
	input  logic out_last,
	output int fail_count,
	output int pending
);
	localparam int NPAGE = 16;
	localparam int NREC = 64;
	localparam int HDR = 16;

	typedef struct packed {
		logic [2:0] status;
		logic signed [4:0] page;
		logic signed [6:0] slot;
		logic [6:0] count;
		logic [4:0] pages;
		logic last;
	} line_t;

	logic [15:0] size_reg;
	logic [15:0] free_bytes [NPAGE];
	logic [6:0] rec_count [NPAGE];
	logic signed [31:0] dir_key [NPAGE][NREC];
	logic [15:0] dir_size [NPAGE][NREC];
	int n_pages;
	line_t expected_lines [$];

	assign pending = expected_lines.size();

	function automatic line_t mk(logic [2:0] st, int pg, int sl, int cnt, logic lst);
		line_t l;
		l.status = st;
		l.page = pg[4:0];
		l.slot = sl[6:0];
		l.count = cnt[6:0];
		l.pages = n_pages[4:0];
		l.last = lst;
		return l;
	endfunction

	// queue one expected result at the tail
	function automatic void add_line(line_t l);
		expected_lines.insert(expected_lines.size(), l);
	endfunction

	// sorted insert into page p; returns slot
	function automatic int put_record(int p, logic [15:0] sz, logic signed [31:0] k);
		int pos;
		pos = rec_count[p];
		while (pos > 0 && !(dir_key[p][pos-1] < k ||
				(dir_key[p][pos-1] == k && dir_size[p][pos-1] <= sz))) begin
			dir_key[p][pos] = dir_key[p][pos-1];
			dir_size[p][pos] = dir_size[p][pos-1];
			pos--;
		end
		dir_key[p][pos] = k;
		dir_size[p][pos] = sz;
		rec_count[p] = rec_count[p] + 7'd1;
		free_bytes[p] = 16'(free_bytes[p] - (sz + 17'd4));
		return pos;
	endfunction

	task automatic predict_item(logic [1:0] md, logic [15:0] sz, logic signed [31:0] k);
		int best, p, s;
		logic [16:0] cost;
		bit hit;
		cost = sz + 17'd4;
		hit = 0;
		case (md)
			MODE_INSERT: begin
				if (n_pages > 0) begin
					best = 0;
					for (p = 1; p < n_pages; p++)
						if (free_bytes[p] > free_bytes[best]) best = p;
					if (free_bytes[best] >= cost) begin
						hit = 1;
						if (rec_count[best] >= NREC)
							add_line(mk(ST_DIR_FULL, best, -1, rec_count[best], 1));
						else begin
							s = put_record(best, sz, k);
							add_line(mk(ST_INSERTED, best, s, rec_count[best], 1));
						end
					end
				end
				if (!hit) begin
					if (n_pages >= NPAGE)
						add_line(mk(ST_TABLE_FULL, -1, -1, 0, 1));
					else begin
						p = n_pages;
						free_bytes[p] = (size_reg > 16'(HDR)) ? size_reg - 16'(HDR) : 16'd0;
						rec_count[p] = 0;
						n_pages++;
						if (free_bytes[p] >= cost) begin
							s = put_record(p, sz, k);
							add_line(mk(ST_INSERTED, p, s, rec_count[p], 1));
						end else
							add_line(mk(ST_FAILED, p, -1, 0, 1));
					end
				end
			end
			MODE_SEARCH: begin
				for (p = 0; p < n_pages && !hit; p++)
					for (s = 0; s < rec_count[p] && !hit; s++)
						if (dir_key[p][s] == k) begin
							hit = 1;
							add_line(mk(ST_FOUND, p, s, rec_count[p], 1));
						end
				if (!hit) add_line(mk(ST_NOT_FOUND, -1, -1, 0, 1));
			end
			MODE_DISPLAY: begin
				if (n_pages == 0)
					add_line(mk(ST_DISPLAY, -1, -1, 0, 1));
				for (p = 0; p < n_pages; p++)
					add_line(mk(ST_DISPLAY, p, -1, rec_count[p], p + 1 == n_pages));
			end
			default: ;
		endcase
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		line_t got, want;
		if (!arst_n) begin
			size_reg <= 16'd4096;
			n_pages = 0;
			fail_count <= 0;
			expected_lines.delete();
		end else begin
			if (cfg_we) size_reg <= cfg_data;
			if (in_valid && in_ready) predict_item(in_mode, in_size, in_key);
			if (out_valid && out_ready) begin
				got = {out_status, out_page, out_slot, out_count, out_pages, out_last};
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_lines.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import wfrps_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_data = '0;
	logic out_ready = 0;
	int fail_count, pending;
	int idle_pct = 0, stall_pct = 0;

	wfrps_in_if in_ch();
	wfrps_out_if out_ch();

	initial begin
		in_ch.valid = 0;
		in_ch.mode = '0;
		in_ch.record_size = '0;
		in_ch.key = '0;
	end

	worst_fit_record_page_store u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	assign out_ch.ready = out_ready;

	wfrps_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
		.in_size(in_ch.record_size), .in_key(in_ch.key),
		.out_valid(out_ch.valid), .out_ready(out_ready), .out_status(out_ch.status),
		.out_page(out_ch.page_number), .out_slot(out_ch.slot_number),
		.out_count(out_ch.records_in_page), .out_pages(out_ch.pages_in_use),
		.out_last(out_ch.last_result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// random receiver stall
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// hold one transfer until accepted, with optional idle cycles before it
	task automatic send_item(logic [1:0] md, logic [15:0] sz, logic [31:0] k);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.mode <= md;
		in_ch.record_size <= sz;
		in_ch.key <= k;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// drop valid and wait for every expected result
	task automatic drain_results();
		in_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_pg_bytes(logic [15:0] v);
		drain_results();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_item(int key_span);
		int r;
		logic [31:0] k;
		r = $urandom_range(99);
		k = (key_span == 0) ? $urandom() : $urandom_range(key_span) - key_span / 2;
		if (r < 60)
			send_item(MODE_INSERT, ($urandom_range(9) == 0) ? 16'($urandom()) :
				16'($urandom_range(300)), k);
		else if (r < 85) send_item(MODE_SEARCH, 16'($urandom()), k);
		else if (r < 95) send_item(MODE_DISPLAY, 16'($urandom()), k);
		else send_item(2'd3, 16'($urandom()), k);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty store behavior
		send_item(MODE_DISPLAY, 0, 0);
		send_item(MODE_SEARCH, 0, 32'h8000_0000);
		send_item(2'd3, 16'hffff, 32'hffff_ffff);
		// key extremes and ordering on equal keys
		send_item(MODE_INSERT, 16'd0, 32'h7fff_ffff);
		send_item(MODE_INSERT, 16'd100, 32'h8000_0000);
		send_item(MODE_INSERT, 16'd50, 32'h8000_0000);
		send_item(MODE_INSERT, 16'd10, 32'd0);
		send_item(MODE_INSERT, 16'hffff, 32'd5);
		send_item(MODE_SEARCH, 0, 32'h8000_0000);
		send_item(MODE_SEARCH, 0, 32'h7fff_ffff);
		send_item(MODE_DISPLAY, 0, 0);
		// pages below header size, then exact fit
		write_pg_bytes(16'd0);
		send_item(MODE_INSERT, 16'd5000, 32'd1);
		send_item(MODE_INSERT, 16'd0, 32'd2);
		write_pg_bytes(16'd17);
		write_pg_bytes(16'd24);
		send_item(MODE_INSERT, 16'd4000, 32'd3);
		send_item(MODE_INSERT, 16'd4, 32'd3);
		send_item(MODE_DISPLAY, 0, 0);

		// tiny pages to reach page table full
		write_pg_bytes(16'd20);
		repeat (16) send_item(MODE_INSERT, 16'd1, $urandom());
		send_item(MODE_DISPLAY, 0, 0);
		drain_results();

		// phases of input idling and receiver stalls; no reset, so the store is not fresh; big pages for directory full
		write_pg_bytes(16'hffff);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 10) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 10) : 0;
			repeat (22) random_item(ph[0] ? 0 : 40);
			if (ph == 1) write_pg_bytes(16'($urandom_range(17, 65535)));
		end
		idle_pct = 0;
		stall_pct = 0;
		drain_results();
		if (fail_count == 0) begin
			$display("** worst_fit_record_page_store: PASSED **");
		end else begin
			$display("** worst_fit_record_page_store: FAILED **");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("** worst_fit_record_page_store: FAILED **");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/wfrps_pkg.sv
design/wfrps_if.sv
design/wfrps_ctrl.sv
design/wfrps_dpath.sv
design/worst_fit_record_page_store.sv
tb/sv/wfrps_chk.sv
tb/sv/tb_top.sv
